/* hw/rtl/xcs_pkg.sv */
// Package for the XMODEM-CRC sender: word types, protocol codes and the CRC step.
// No dependencies; xcs_core and xmodem_crc_sender import it.
package xcs_pkg;

    // Event codes carried in the command field of an input word.
    typedef enum logic [2:0] {
        CMD_PAYLOAD = 3'd0,
        CMD_EOF     = 3'd1,
        CMD_LINE    = 3'd2,
        CMD_TIMEOUT = 3'd3,
        CMD_SLOT    = 3'd4,
        CMD_START   = 3'd5
    } t_cmd;

    // Protocol phase as reported in every result word.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_AWAIT = 3'd1,
        PH_FILL  = 3'd2,
        PH_SEND  = 3'd3,
        PH_REPLY = 3'd4,
        PH_DONE  = 3'd5,
        PH_ABORT = 3'd6
    } t_phase;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NOT_READY = 2'd1;
    localparam logic [1:0] ERR_LOST_SYNC = 2'd2;
    localparam logic [1:0] ERR_FAILURES  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_USE_1K     = 2'd0;
    localparam logic [1:0] CFG_RETRY      = 2'd1;
    localparam logic [1:0] CFG_START_TRIES = 2'd2;

    // Line bytes.
    localparam logic [7:0] B_SOH  = 8'h01;
    localparam logic [7:0] B_STX  = 8'h02;
    localparam logic [7:0] B_EOT  = 8'h04;
    localparam logic [7:0] B_ACK  = 8'h06;
    localparam logic [7:0] B_NAK  = 8'h15;
    localparam logic [7:0] B_PAD  = 8'h1A;
    localparam logic [7:0] B_CRCQ = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Packet sizes and counter width.
    localparam int unsigned CNT_W = 11;
    localparam logic [CNT_W-1:0] PKT_SMALL = 11'd128;
    localparam logic [CNT_W-1:0] PKT_LARGE = 11'd1024;

    // Reset values of the configuration registers.
    localparam logic [3:0] RETRY_RESET = 4'd10;
    localparam logic [3:0] TRIES_RESET = 4'd10;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] byte_in;
    } t_in_word;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       accepted;
        t_phase     phase;
        logic [1:0] error_code;
        logic [7:0] packet_number;
    } t_out_word;

    typedef struct packed {
        logic       use_1k;
        logic [3:0] retry_limit;
        logic [3:0] start_attempts;
    } t_cfg;

    // One byte of CRC-16/XMODEM, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/xcs_store.sv */
// Packet buffer of the XMODEM-CRC sender: one write port, one registered read port.
// Depends on nothing but its parameters.
module xcs_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/xcs_core.sv */
// Protocol engine of the XMODEM-CRC sender: phase, counters, CRC and result word.
// Depends on xcs_pkg; drives the packet buffer in xcs_store.
module xcs_core #(
    parameter int unsigned MAX_PACKET = 1024,
    parameter int unsigned AW         = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  xcs_pkg::t_in_word   i_word,
    input  xcs_pkg::t_cfg       i_cfg,
    input  logic [7:0]          i_rd_data,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [7:0]          o_wr_data,
    output logic [AW-1:0]       o_rd_addr,
    output xcs_pkg::t_out_word  o_result
);
    import xcs_pkg::*;

    localparam bit ALLOW_1K = (MAX_PACKET >= 1024);

    t_phase           r_phase, n_phase;
    logic [1:0]       r_err, n_err;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_fpos, n_fpos;
    logic [7:0]       r_seq, n_seq;
    logic [15:0]      r_crc, n_crc;
    logic [3:0]       r_att, n_att;
    logic             r_eof, n_eof;
    logic             r_eot, n_eot;
    logic             r_big, n_big;

    logic [CNT_W-1:0] size_now;
    logic [CNT_W-1:0] data_idx;
    logic [CNT_W-1:0] rd_pos;
    logic [3:0]       att_inc;
    logic [7:0]       data_byte;
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             acc;

    assign size_now  = r_big ? PKT_LARGE : PKT_SMALL;
    assign data_idx  = r_fpos - 11'd3;
    assign att_inc   = r_att + 4'd1;
    // Buffer output holds the byte at data_idx, read ahead through the registered read port.
    assign data_byte = (data_idx < r_fill) ? i_rd_data : B_PAD;

    // Next-state and result logic for one event.
    always_comb begin
        n_phase  = r_phase;
        n_err    = r_err;
        n_fill   = r_fill;
        n_fpos   = r_fpos;
        n_seq    = r_seq;
        n_crc    = r_crc;
        n_att    = r_att;
        n_eof    = r_eof;
        n_eot    = r_eot;
        n_big    = r_big;
        tx_valid = 1'b0;
        tx_byte  = 8'h00;
        acc      = 1'b0;
        o_wr_en  = 1'b0;

        case (i_word.command)
            CMD_START: begin
                n_phase = PH_AWAIT;
                n_err   = ERR_NONE;
                n_fill  = '0;
                n_fpos  = '0;
                n_seq   = 8'd0;
                n_crc   = 16'd0;
                n_att   = 4'd0;
                n_eof   = 1'b0;
                n_eot   = 1'b0;
                n_big   = i_cfg.use_1k && ALLOW_1K;
            end
            CMD_PAYLOAD: begin
                if (r_phase == PH_FILL && r_fill < size_now) begin
                    o_wr_en = 1'b1;
                    acc     = 1'b1;
                    n_fill  = r_fill + 11'd1;
                    // A full packet starts its frame at once.
                    if (n_fill >= size_now) begin
                        n_att   = 4'd0;
                        n_phase = PH_SEND;
                        n_fpos  = '0;
                        n_crc   = 16'd0;
                    end
                end
            end
            CMD_EOF: begin
                if (r_phase == PH_FILL) begin
                    n_eof   = 1'b1;
                    n_att   = 4'd0;
                    if (r_fill == '0) begin
                        n_eot = 1'b1;
                    end
                    n_phase = PH_SEND;
                    n_fpos  = '0;
                    n_crc   = 16'd0;
                end else if (r_phase == PH_SEND || r_phase == PH_REPLY) begin
                    n_eof = 1'b1;
                end
            end
            CMD_SLOT: begin
                if (r_phase == PH_SEND) begin
                    tx_valid = 1'b1;
                    if (r_eot) begin
                        tx_byte = B_EOT;
                        n_att   = att_inc;
                        n_phase = PH_REPLY;
                    end else if (r_fpos == 11'd0) begin
                        tx_byte = r_big ? B_STX : B_SOH;
                    end else if (r_fpos == 11'd1) begin
                        tx_byte = r_seq;
                    end else if (r_fpos == 11'd2) begin
                        tx_byte = ~r_seq;
                    end else if (r_fpos < size_now + 11'd3) begin
                        tx_byte = data_byte;
                        n_crc   = crc_byte(r_crc, data_byte);
                    end else if (r_fpos == size_now + 11'd3) begin
                        tx_byte = r_crc[15:8];
                    end else begin
                        tx_byte = r_crc[7:0];
                        n_att   = att_inc;
                        n_phase = PH_REPLY;
                    end
                    n_fpos = r_fpos + 11'd1;
                end
            end
            CMD_LINE, CMD_TIMEOUT: begin
                if (r_phase == PH_AWAIT) begin
                    // Receiver start request, or one more failed attempt.
                    if (i_word.command == CMD_LINE
                            && (i_word.byte_in == B_NAK || i_word.byte_in == B_CRCQ)) begin
                        n_phase = PH_FILL;
                        n_seq   = 8'd1;
                        n_fill  = '0;
                        n_att   = 4'd0;
                    end else begin
                        n_att = att_inc;
                        if (att_inc >= i_cfg.start_attempts) begin
                            n_phase = PH_ABORT;
                            n_err   = ERR_NOT_READY;
                        end
                    end
                end else if (r_phase == PH_REPLY) begin
                    if (i_word.command == CMD_LINE && i_word.byte_in == B_ACK) begin
                        if (r_eot) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_seq  = r_seq + 8'd1;
                            n_fill = '0;
                            n_att  = 4'd0;
                            if (r_eof) begin
                                n_eot   = 1'b1;
                                n_phase = PH_SEND;
                                n_fpos  = '0;
                                n_crc   = 16'd0;
                            end else begin
                                n_phase = PH_FILL;
                            end
                        end
                    end else if (i_word.command == CMD_LINE && i_word.byte_in == B_NAK) begin
                        if (r_att >= i_cfg.retry_limit) begin
                            n_phase = PH_ABORT;
                            n_err   = ERR_FAILURES;
                        end else begin
                            n_phase = PH_SEND;
                            n_fpos  = '0;
                            n_crc   = 16'd0;
                        end
                    end else begin
                        n_phase = PH_ABORT;
                        n_err   = ERR_LOST_SYNC;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Buffer ports: write at the fill count, prefetch the byte the next slot needs.
    assign o_wr_addr = r_fill[AW-1:0];
    assign o_wr_data = i_word.byte_in;
    assign rd_pos    = (i_accept ? n_fpos : r_fpos) - 11'd3;
    assign o_rd_addr = rd_pos[AW-1:0];

    // Result word after this event.
    always_comb begin
        o_result.tx_valid      = tx_valid;
        o_result.tx_byte       = tx_byte;
        o_result.accepted      = acc;
        o_result.phase         = n_phase;
        o_result.error_code    = n_err;
        o_result.packet_number = n_seq;
    end

    // Protocol state, updated on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_err   <= ERR_NONE;
            r_fill  <= '0;
            r_fpos  <= '0;
            r_seq   <= 8'd0;
            r_crc   <= 16'd0;
            r_att   <= 4'd0;
            r_eof   <= 1'b0;
            r_eot   <= 1'b0;
            r_big   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_fill  <= n_fill;
            r_fpos  <= n_fpos;
            r_seq   <= n_seq;
            r_crc   <= n_crc;
            r_att   <= n_att;
            r_eof   <= n_eof;
            r_eot   <= n_eot;
            r_big   <= n_big;
        end
    end

endmodule

/* hw/rtl/xmodem_crc_sender.sv */
// Top level of the XMODEM-CRC sender: handshakes, configuration registers, result register.
// Depends on xcs_pkg, xcs_core and xcs_store.
//
// Usage: every event (payload byte, end of file, received line byte, timeout,
// transmit slot, start) is one input word on the i_in_valid / o_in_ready
// channel. Each accepted word yields exactly one result word on o_out_valid /
// i_out_ready, carrying the byte to transmit (for a transmit slot), whether a
// payload byte was taken, and the phase, error and packet number after the event.
// The result is registered: it is in the output register after the edge on which
// the word is accepted. Throughput is one word per cycle while the receiver takes
// results; the rate is set by the single protocol update per word, and the buffer
// read for the next data byte is issued ahead so it never stalls a transmit slot.
// When the receiver stalls, the result waits in the output register, and a new
// word is accepted in the same cycle that the waiting one is taken.
// Configuration writes (index 0 packet size, 1 retry limit, 2 start attempts)
// are always ready and take effect at once; the packet size is latched at start.
// Reset clears the protocol state to idle and the registers to their defaults;
// the packet buffer is not cleared and needs no clearing pass.
module xmodem_crc_sender #(
    parameter int unsigned MAX_PACKET = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  xcs_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output xcs_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);
    import xcs_pkg::*;

    localparam int unsigned AW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;

    t_cfg       r_cfg;
    logic       r_out_valid;
    t_out_word  r_out_word;
    logic       accept;
    t_out_word  result;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.use_1k         <= 1'b0;
            r_cfg.retry_limit    <= RETRY_RESET;
            r_cfg.start_attempts <= TRIES_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_USE_1K:      r_cfg.use_1k         <= i_cfg_data[0];
                CFG_RETRY:       r_cfg.retry_limit    <= i_cfg_data;
                CFG_START_TRIES: r_cfg.start_attempts <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    xcs_core #(
        .MAX_PACKET (MAX_PACKET),
        .AW         (AW)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_word    (i_in_word),
        .i_cfg     (r_cfg),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .o_result  (result)
    );

    xcs_store #(
        .DEPTH (MAX_PACKET),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: holds a word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
